// File: hdl/ria_pkg.sv
// ----------------------------------------------------------------------------
// ria_pkg
// Shared widths, codes, types and helpers for the recycling ID allocator.
// ----------------------------------------------------------------------------
package ria_pkg;

  // Identifier layout
  localparam int INDEX_BITS  = 10;
  localparam int GROUP_BITS  = 4;
  localparam int ID_BITS     = INDEX_BITS + GROUP_BITS;
  localparam int MIN_INDEX   = 1;

  // Recycle queue geometry
  localparam int QUEUE_DEPTH = 1024;
  localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

  // Command queue between front and back
  localparam int CQ_DEPTH    = 4;
  localparam int CQ_PTR_BITS = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_BITS = $clog2(CQ_DEPTH + 1);

  localparam int FUNC_BITS   = 2;
  localparam int STATUS_BITS = 3;

  // Request codes
  localparam logic [FUNC_BITS-1:0] FN_GENERATE     = 2'd0;
  localparam logic [FUNC_BITS-1:0] FN_FREE         = 2'd1;
  localparam logic [FUNC_BITS-1:0] FN_IMPORT_START = 2'd2;
  localparam logic [FUNC_BITS-1:0] FN_IMPORT_ENTRY = 2'd3;

  // Status codes
  localparam logic [STATUS_BITS-1:0] STS_OK      = 3'd0;
  localparam logic [STATUS_BITS-1:0] STS_OUT     = 3'd1;
  localparam logic [STATUS_BITS-1:0] STS_INVALID = 3'd2;
  localparam logic [STATUS_BITS-1:0] STS_GROUP   = 3'd3;
  localparam logic [STATUS_BITS-1:0] STS_ABOVE   = 3'd4;
  localparam logic [STATUS_BITS-1:0] STS_BELOW   = 3'd5;
  localparam logic [STATUS_BITS-1:0] STS_FULL    = 3'd6;

  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [GROUP_BITS-1:0] group_t;
  typedef logic [PTR_BITS-1:0]   ptr_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;

  // Classified request as it travels from front to back
  typedef struct packed {
    logic [FUNC_BITS-1:0] op;
    group_t               id_group;
    index_t               id_index;
    logic                 id_invalid;
    logic                 id_below;
    index_t               ridx;
    logic                 ridx_below;
    logic                 last;
  } cmd_t;

  // Circular pointer advance
  function automatic ptr_t next_slot(input ptr_t p);
    return (p == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
  endfunction

endpackage

// File: hdl/ria_front.sv
// ----------------------------------------------------------------------------
// ria_front
// Input register: takes request transfers and classifies the fields that do
// not depend on allocator state.
// ----------------------------------------------------------------------------
module ria_front import ria_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic [FUNC_BITS-1:0]   func,
  input  logic [ID_BITS-1:0]     id,
  input  index_t                 restore_index,
  input  logic                   last,
  input  logic                   q_full,
  output logic                   q_wr,
  output cmd_t                   q_data
);

  logic valid;
  logic valid_next;
  cmd_t cmd;
  cmd_t cmd_class;
  logic accept;

  // Stall only while holding an item the queue cannot take
  assign full   = valid && q_full;
  assign accept = push && !full;
  assign q_wr   = valid && !q_full;
  assign q_data = cmd;

  // Classification of the raw fields
  always_comb begin
    cmd_class.op         = func;
    cmd_class.id_group   = id[ID_BITS-1:INDEX_BITS];
    cmd_class.id_index   = id[INDEX_BITS-1:0];
    cmd_class.id_invalid = (id == {ID_BITS{1'b1}});
    cmd_class.id_below   = (id[INDEX_BITS-1:0] < INDEX_BITS'(MIN_INDEX));
    cmd_class.ridx       = restore_index;
    cmd_class.ridx_below = (restore_index < INDEX_BITS'(MIN_INDEX));
    cmd_class.last       = last;
  end

  assign valid_next = accept || (valid && q_full);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_class;
    end
  end

endmodule

// File: hdl/ria_cmdq.sv
// ----------------------------------------------------------------------------
// ria_cmdq
// Short FIFO of classified requests between front and back.
// ----------------------------------------------------------------------------
module ria_cmdq import ria_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wr_data,
  output logic q_full,
  input  logic rd,
  output cmd_t rd_data,
  output logic q_empty
);

  cmd_t                   slots [CQ_DEPTH];
  logic [CQ_PTR_BITS-1:0] wptr;
  logic [CQ_PTR_BITS-1:0] rptr;
  logic [CQ_CNT_BITS-1:0] count;
  logic                   do_wr;
  logic                   do_rd;

  assign q_full  = (count == CQ_CNT_BITS'(CQ_DEPTH));
  assign q_empty = (count == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_data = slots[rptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == CQ_PTR_BITS'(CQ_DEPTH - 1)) ? '0 : CQ_PTR_BITS'(wptr + 1'b1);
      end
      if (do_rd) begin
        rptr <= (rptr == CQ_PTR_BITS'(CQ_DEPTH - 1)) ? '0 : CQ_PTR_BITS'(rptr + 1'b1);
      end
      if (do_wr && !do_rd) begin
        count <= CQ_CNT_BITS'(count + 1'b1);
      end else if (do_rd && !do_wr) begin
        count <= CQ_CNT_BITS'(count - 1'b1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_data;
    end
  end

endmodule

// File: hdl/ria_back.sv
// ----------------------------------------------------------------------------
// ria_back
// Execution engine: recycle memory, queue pointers, fresh counter, batch
// error tracking and the result register.
// ----------------------------------------------------------------------------
module ria_back import ria_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  group_t                 group_id,
  input  logic                   cmd_empty,
  input  cmd_t                   cmd,
  output logic                   cmd_pop,
  output logic                   empty,
  input  logic                   pop,
  output logic [STATUS_BITS-1:0] status,
  output logic [ID_BITS-1:0]     new_id
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state, state_next;

  ptr_t   qhead, qhead_next;
  ptr_t   qtail, qtail_next;
  cnt_t   qcount, qcount_next;
  ptr_t   ptail, ptail_next;
  cnt_t   pcount, pcount_next;
  index_t fresh, fresh_next;
  logic [STATUS_BITS-1:0] berr, berr_next;

  logic                   res_valid, res_valid_next;
  logic [STATUS_BITS-1:0] res_status, res_status_next;
  logic [ID_BITS-1:0]     res_id, res_id_next;

  index_t mem [QUEUE_DEPTH];
  index_t rdata;
  logic   rd_en;
  logic   mem_we;
  ptr_t   mem_waddr;
  index_t mem_wdata;

  logic [CNT_BITS:0]      used;
  logic                   store_full;
  logic [STATUS_BITS-1:0] chk;
  logic [STATUS_BITS-1:0] err;
  ptr_t                   pt;
  cnt_t                   pc;
  ptr_t                   qt;

  assign empty  = !res_valid;
  assign status = res_status;
  assign new_id = res_id;

  // Committed plus pending entries against capacity
  assign used       = {1'b0, qcount} + {1'b0, pcount};
  assign store_full = (used >= (CNT_BITS + 1)'(QUEUE_DEPTH));

  // Free check, in priority order
  always_comb begin
    priority if (cmd.id_invalid) begin
      chk = STS_INVALID;
    end else if (cmd.id_group != group_id) begin
      chk = STS_GROUP;
    end else if (cmd.id_index >= fresh) begin
      chk = STS_ABOVE;
    end else if (cmd.id_below) begin
      chk = STS_BELOW;
    end else if (store_full) begin
      chk = STS_FULL;
    end else begin
      chk = STS_OK;
    end
  end

  // Request execution
  always_comb begin
    state_next      = state;
    qhead_next      = qhead;
    qtail_next      = qtail;
    qcount_next     = qcount;
    ptail_next      = ptail;
    pcount_next     = pcount;
    fresh_next      = fresh;
    berr_next       = berr;
    res_valid_next  = res_valid && !pop;
    res_status_next = res_status;
    res_id_next     = res_id;
    cmd_pop         = 1'b0;
    rd_en           = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = ptail;
    mem_wdata       = cmd.id_index;
    err             = berr;
    pt              = ptail;
    pc              = pcount;
    qt              = qtail;

    if (state == S_READ) begin
      // Recycled index arrives from memory
      res_valid_next  = 1'b1;
      res_status_next = STS_OK;
      res_id_next     = {group_id, rdata};
      state_next      = S_IDLE;
    end else if (!cmd_empty && !res_valid) begin
      cmd_pop = 1'b1;
      unique case (cmd.op)
        FN_GENERATE: begin
          if (qcount != '0) begin
            rd_en       = 1'b1;
            qhead_next  = next_slot(qhead);
            qcount_next = cnt_t'(qcount - 1'b1);
            state_next  = S_READ;
          end else if (fresh == {INDEX_BITS{1'b1}}) begin
            res_valid_next  = 1'b1;
            res_status_next = STS_OUT;
            res_id_next     = '0;
          end else begin
            res_valid_next  = 1'b1;
            res_status_next = STS_OK;
            res_id_next     = {group_id, fresh};
            fresh_next      = index_t'(fresh + 1'b1);
          end
        end
        FN_FREE: begin
          if (berr == STS_OK) begin
            if (chk != STS_OK) begin
              err = chk;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = ptail;
              mem_wdata = cmd.id_index;
              pt        = next_slot(ptail);
              pc        = cnt_t'(pcount + 1'b1);
            end
          end
          berr_next   = err;
          ptail_next  = pt;
          pcount_next = pc;
          // End of batch: commit all or nothing
          if (cmd.last) begin
            if (err == STS_OK) begin
              qt          = pt;
              qcount_next = cnt_t'(qcount + pc);
            end
            qtail_next      = qt;
            ptail_next      = qt;
            pcount_next     = '0;
            res_valid_next  = 1'b1;
            res_status_next = err;
            res_id_next     = '0;
            berr_next       = STS_OK;
          end
        end
        FN_IMPORT_START: begin
          pcount_next = '0;
          if (cmd.ridx_below) begin
            err        = STS_BELOW;
            ptail_next = qtail;
          end else begin
            err         = STS_OK;
            fresh_next  = cmd.ridx;
            qhead_next  = '0;
            qtail_next  = '0;
            ptail_next  = '0;
            qcount_next = '0;
          end
          berr_next = err;
          if (cmd.last) begin
            res_valid_next  = 1'b1;
            res_status_next = err;
            res_id_next     = '0;
            berr_next       = STS_OK;
          end
        end
        FN_IMPORT_ENTRY: begin
          pcount_next = '0;
          ptail_next  = qtail;
          if (berr == STS_OK) begin
            if (qcount == CNT_BITS'(QUEUE_DEPTH)) begin
              err = STS_FULL;
            end else begin
              mem_we      = 1'b1;
              mem_waddr   = qtail;
              mem_wdata   = cmd.ridx;
              qt          = next_slot(qtail);
              qtail_next  = qt;
              ptail_next  = qt;
              qcount_next = cnt_t'(qcount + 1'b1);
            end
          end
          berr_next = err;
          if (cmd.last) begin
            res_valid_next  = 1'b1;
            res_status_next = err;
            res_id_next     = '0;
            berr_next       = STS_OK;
          end
        end
        default: begin
          cmd_pop = 1'b1;
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      qhead     <= '0;
      qtail     <= '0;
      qcount    <= '0;
      ptail     <= '0;
      pcount    <= '0;
      fresh     <= INDEX_BITS'(MIN_INDEX);
      berr      <= STS_OK;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      qhead     <= qhead_next;
      qtail     <= qtail_next;
      qcount    <= qcount_next;
      ptail     <= ptail_next;
      pcount    <= pcount_next;
      fresh     <= fresh_next;
      berr      <= berr_next;
      res_valid <= res_valid_next;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_id     <= res_id_next;
  end

  // Recycle memory: one write port, registered read at the queue head
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rdata <= mem[qhead];
    end
  end

  // Committed and pending entries never exceed capacity
  a_capacity: assert property (@(posedge clk) disable iff (rst)
    used <= (CNT_BITS + 1)'(QUEUE_DEPTH))
    else $error("recycle queue over capacity");

  // Fresh counter never drops below the minimum index
  a_fresh_min: assert property (@(posedge clk) disable iff (rst)
    fresh >= INDEX_BITS'(MIN_INDEX))
    else $error("fresh counter below minimum");

  // A memory read is only started with the result register free
  a_read_slot: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> !res_valid)
    else $error("memory read with result pending");

  // An error result always carries a zero identifier
  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_status != STS_OK |-> res_id == '0)
    else $error("error result with nonzero id");

  // Memory read completes into the result register next cycle
  a_read_done: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> res_valid && res_status == STS_OK)
    else $error("recycled id not delivered");

endmodule

// File: hdl/recycling_id_allocator.sv
// ----------------------------------------------------------------------------
// recycling_id_allocator
// Issues group/index identifiers from a FIFO of freed indices or a fresh
// counter, with batched frees and queue import, behind queue-style ports.
// ----------------------------------------------------------------------------
// Path: a request passes the front register, the command queue and the
//   result register; a generate served from the recycle memory also passes
//   the registered memory read.
// Flow: requests that give no result run back to back while the single
//   result register is empty; it must be popped before the next request runs.
// Reset: synchronous; queue empty, fresh counter at the minimum index, no
//   batch error, group_id zero. Recycle memory needs no clearing.
// ----------------------------------------------------------------------------
module recycling_id_allocator import ria_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // APB-style configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [1:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  // Requests
  input  logic                   push,
  output logic                   full,
  input  logic [FUNC_BITS-1:0]   func,
  input  logic [ID_BITS-1:0]     id,
  input  logic [INDEX_BITS-1:0]  restore_index,
  input  logic                   last,
  // Results
  output logic                   empty,
  input  logic                   pop,
  output logic [STATUS_BITS-1:0] status,
  output logic [ID_BITS-1:0]     new_id
);

  localparam logic [1:0] ADDR_GROUP_ID = 2'd0;

  group_t group_id;
  logic   q_full;
  logic   q_wr;
  cmd_t   q_wdata;
  logic   q_empty;
  logic   q_rd;
  cmd_t   q_rdata;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_GROUP_ID) ? {{(32 - GROUP_BITS){1'b0}}, group_id} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_id <= '0;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_GROUP_ID) begin
      group_id <= pwdata[GROUP_BITS-1:0];
    end
  end

  // Front: request transfer and classification
  ria_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .func          (func),
    .id            (id),
    .restore_index (restore_index),
    .last          (last),
    .q_full        (q_full),
    .q_wr          (q_wr),
    .q_data        (q_wdata)
  );

  // Decoupling queue
  ria_cmdq u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_wr),
    .wr_data (q_wdata),
    .q_full  (q_full),
    .rd      (q_rd),
    .rd_data (q_rdata),
    .q_empty (q_empty)
  );

  // Back: execution and result register
  ria_back u_back (
    .clk       (clk),
    .rst       (rst),
    .group_id  (group_id),
    .cmd_empty (q_empty),
    .cmd       (q_rdata),
    .cmd_pop   (q_rd),
    .empty     (empty),
    .pop       (pop),
    .status    (status),
    .new_id    (new_id)
  );

endmodule
